@@ hw/rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Sizes, pointer width, command and status codes, control/status structs.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int BUCKETS    = 128;
	localparam int NODES      = 256;
	localparam int VALUE_BITS = 32;
	localparam int KEY_BITS   = 32;
	localparam int PTR_BITS   = $clog2(NODES + 1);
	localparam int BKT_BITS   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int BCNT_BITS  = 8;
	localparam int NIDX_BITS  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(NODES);
	localparam logic [BCNT_BITS-1:0] BCNT_RESET = 8'd10;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture command, begin modulo
		logic mod_step;   // one restoring-division bit
		logic head_rd;    // read bucket head
		logic alloc;      // perform insert
		logic node_rd;    // issue node read at cur
		logic advance;    // prev <= cur, cur <= link
		logic unlink;     // perform delete of cur
		logic finish;     // drive result strobe
		logic hit;        // result is success
		logic full;       // result is pool full
	} cht_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       mod_done;
		logic       cur_nil;
		logic       key_match;
		logic       can_alloc;
		logic       step_limit;
	} cht_sts_t;

endpackage

@@ hw/rtl/cht_datapath.sv @@
// ----------------------------------------------------------------------------
// cht_datapath: bucket heads, node memories, free list and bucket modulo
// Holds all table state and performs operations on controller commands.
// ----------------------------------------------------------------------------
module cht_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  cmd,
	input  logic [cht_pkg::KEY_BITS-1:0] key,
	input  logic [31:0]                 value,
	input  logic                        cfg_we,
	input  logic [7:0]                  cfg_data,
	input  cht_pkg::cht_ctl_t           ctl,
	output cht_pkg::cht_sts_t           sts,
	output logic [31:0]                 found_value
);
	import cht_pkg::*;

	localparam int STEP_BITS = $clog2(NODES + 1);

	logic [BCNT_BITS-1:0]  bcnt_q;
	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [KEY_BITS-1:0]   rem_q;     // running remainder / dividend bits
	logic [KEY_BITS-1:0]   quo_q;     // remaining dividend bits to shift in
	logic [5:0]            mbit_q;
	logic [BKT_BITS-1:0]   div_q;
	logic [BKT_BITS-1:0]   bkt_q;
	logic [PTR_BITS-1:0]   cur_q, prev_q, free_q;
	logic [PTR_BITS:0]     unused_q;
	logic [STEP_BITS-1:0]  steps_q;

	logic [PTR_BITS-1:0]   heads_q [BUCKETS];
	logic [BUCKETS-1:0]    hvalid_q;
	logic [KEY_BITS-1:0]   nkey_mem  [NODES];
	logic [VALUE_BITS-1:0] nval_mem  [NODES];
	logic [PTR_BITS-1:0]   nlink_mem [NODES];
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [PTR_BITS-1:0]   rd_link_q;
	logic [PTR_BITS-1:0]   head_rd_q;
	logic                  head_hv_q;
	logic [PTR_BITS-1:0]   free_link_q;

	logic [PTR_BITS-1:0]   head_val;
	logic [KEY_BITS:0]     trial;
	logic [BKT_BITS-1:0]   bkt_nxt;
	logic                  mod_last;
	logic [NIDX_BITS-1:0]  new_idx;
	logic [NIDX_BITS-1:0]  cur_idx, prev_idx, wr_idx;
	logic                  from_free;
	logic                  nwe;
	logic [PTR_BITS-1:0]   nlink_wd;
	logic [BCNT_BITS-1:0]  bcnt_eff;

	assign head_val  = head_hv_q ? head_rd_q : NIL;
	assign from_free = (free_q != NIL);
	assign cur_idx   = cur_q[NIDX_BITS-1:0];
	assign prev_idx  = prev_q[NIDX_BITS-1:0];
	assign new_idx   = from_free ? free_q[NIDX_BITS-1:0] : unused_q[NIDX_BITS-1:0];
	assign trial     = {rem_q, quo_q[KEY_BITS-1]} - {{(KEY_BITS+1-BKT_BITS){1'b0}}, div_q};
	assign bkt_nxt   = (!trial[KEY_BITS]) ? trial[BKT_BITS-1:0]
	                                      : {rem_q[BKT_BITS-2:0], quo_q[KEY_BITS-1]};
	assign mod_last  = ctl.mod_step && (mbit_q == 6'(KEY_BITS - 1));

	always_comb begin
		bcnt_eff = bcnt_q;
		if (bcnt_q == '0) begin
			bcnt_eff = BCNT_BITS'(1);
		end else if (32'(bcnt_q) > BUCKETS) begin
			bcnt_eff = BCNT_BITS'(BUCKETS);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= BCNT_RESET;
		end else if (cfg_we) begin
			bcnt_q <= cfg_data;
		end
	end

	// command capture and bit-serial key modulo bucket count
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			key_q  <= key;
			val_q  <= VALUE_BITS'(value);
			rem_q  <= '0;
			quo_q  <= key;
			mbit_q <= '0;
			div_q  <= BKT_BITS'(bcnt_eff);
		end else if (ctl.mod_step) begin
			if (!trial[KEY_BITS]) begin
				rem_q <= trial[KEY_BITS-1:0];
			end else begin
				rem_q <= {rem_q[KEY_BITS-2:0], quo_q[KEY_BITS-1]};
			end
			quo_q  <= {quo_q[KEY_BITS-2:0], 1'b0};
			mbit_q <= mbit_q + 6'd1;
			if (mod_last) begin
				bkt_q <= bkt_nxt;
			end
		end
	end

	// chain walk pointers, free list, allocation mark, bucket heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= NIL;
			unused_q <= '0;
			hvalid_q <= '0;
			cur_q    <= NIL;
			prev_q   <= NIL;
			steps_q  <= '0;
		end else begin
			if (ctl.head_rd) begin
				cur_q   <= head_val;
				prev_q  <= NIL;
				steps_q <= '0;
			end
			if (ctl.advance) begin
				prev_q  <= cur_q;
				cur_q   <= rd_link_q;
				steps_q <= steps_q + 1'b1;
			end
			if (ctl.alloc) begin
				hvalid_q[bkt_q] <= 1'b1;
				if (from_free) begin
					free_q <= (free_link_q > NIL) ? NIL : free_link_q;
				end else begin
					unused_q <= unused_q + 1'b1;
				end
			end
			if (ctl.unlink) begin
				free_q <= cur_q;
				if (prev_q == NIL) begin
					hvalid_q[bkt_q] <= 1'b1;
				end
			end
		end
	end

	// bucket head store; read on the last modulo step at the new bucket
	always_ff @(posedge clk) begin
		if (ctl.alloc) begin
			heads_q[bkt_q] <= {1'b0, new_idx};
		end else if (ctl.unlink && prev_q == NIL) begin
			heads_q[bkt_q] <= rd_link_q;
		end
		if (mod_last) begin
			head_rd_q <= heads_q[bkt_nxt];
			head_hv_q <= hvalid_q[bkt_nxt];
		end
	end

	// node memories: registered reads at the walk pointer and the free head
	always_comb begin
		nwe      = 1'b0;
		wr_idx   = new_idx;
		nlink_wd = head_val;
		if (ctl.alloc) begin
			nwe = 1'b1;
		end else if (ctl.unlink) begin
			nwe      = 1'b1;
			wr_idx   = cur_idx;
			nlink_wd = free_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.alloc) begin
			nkey_mem[wr_idx] <= key_q;
			nval_mem[wr_idx] <= val_q;
		end
		if (nwe) begin
			nlink_mem[wr_idx] <= nlink_wd;
		end
		// relink predecessor around the removed node
		if (ctl.unlink && prev_q != NIL) begin
			nlink_mem[prev_idx] <= rd_link_q;
		end
		if (ctl.node_rd) begin
			rd_key_q  <= nkey_mem[cur_idx];
			rd_val_q  <= nval_mem[cur_idx];
			rd_link_q <= nlink_mem[cur_idx];
		end
		free_link_q <= nlink_mem[free_q[NIDX_BITS-1:0]];
	end

	assign sts.cmd        = cmd_q;
	assign sts.mod_done   = (mbit_q == 6'(KEY_BITS - 1));
	assign sts.cur_nil    = (cur_q >= NIL);
	assign sts.key_match  = (rd_key_q == key_q);
	assign sts.can_alloc  = from_free || (unused_q < (PTR_BITS+1)'(NODES));
	assign sts.step_limit = (steps_q == STEP_BITS'(NODES));

	assign found_value = (ctl.finish && ctl.hit && cmd_q == CMD_SEARCH) ? 32'(rd_val_q) : '0;

endmodule

@@ hw/rtl/cht_ctrl.sv @@
// ----------------------------------------------------------------------------
// cht_ctrl: command sequencer of the chained hash table
// Steps modulo, head read, chain walk and update; issues the result strobe.
// ----------------------------------------------------------------------------
module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cht_pkg::cht_sts_t sts,
	output cht_pkg::cht_ctl_t ctl,
	output logic              busy,
	output logic              done,
	output logic [1:0]        status
);
	import cht_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MOD   = 7'b0000010,
		S_HEAD  = 7'b0000100,
		S_READ  = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_DONE  = 7'b0100000,
		S_INS   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_NOTFOUND;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_MOD;
				end
			end
			S_MOD: begin
				ctl.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				ctl.head_rd = 1'b1;
				st_d = ST_NOTFOUND;
				if (sts.cmd == CMD_INSERT) begin
					state_d = S_INS;
				end else if (sts.cmd == CMD_SEARCH || sts.cmd == CMD_DELETE) begin
					state_d = S_READ;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INS: begin
				if (sts.can_alloc) begin
					ctl.alloc = 1'b1;
					st_d = ST_OK;
				end else begin
					st_d = ST_FULL;
				end
				state_d = S_DONE;
			end
			S_READ: begin
				if (sts.cur_nil || sts.step_limit) begin
					state_d = S_DONE;
				end else begin
					ctl.node_rd = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.key_match) begin
					st_d = ST_OK;
					if (sts.cmd == CMD_DELETE) begin
						ctl.unlink = 1'b1;
					end
					state_d = S_DONE;
				end else begin
					ctl.advance = 1'b1;
					state_d = S_READ;
				end
			end
			S_DONE: begin
				ctl.finish = 1'b1;
				ctl.hit    = (st_q == ST_OK);
				ctl.full   = (st_q == ST_FULL);
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = ctl.finish;
	assign status = ctl.finish ? st_q : ST_OK;

endmodule

@@ hw/rtl/chained_hash_table.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table: key/value store, hash table with separate chaining
//
//  channel   signals                         transfer
//  command   start, cmd, key, value          start && !busy at clk rise
//  result    done, status, found_value       done high for one cycle
//  config    bucket_count_we, bucket_count   write enable at clk rise
//
// A command runs the bit-serial key modulo bucket count (the bucket head is
// read on its last step), a head state, then a memory read and a compare per
// chain node visited, and a result state. Search or delete ends on the
// matching node or at the chain end on a miss; insert adds an allocation
// state, and an undefined command goes from the head state to the result.
// busy drops after the result state.
// Reset clears bucket heads (valid bits), the free list and the allocation
// mark at once; no clearing pass is needed.
// The result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module chained_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        bucket_count_we,
	input  logic [7:0]  bucket_count,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_value
);
	import cht_pkg::*;

	cht_ctl_t ctl;
	cht_sts_t sts;

	// sequence each command through its phases
	cht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	// hold table state and perform the commanded updates
	cht_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key         (key),
		.value       (value),
		.cfg_we      (bucket_count_we),
		.cfg_data    (bucket_count),
		.ctl         (ctl),
		.sts         (sts),
		.found_value (found_value)
	);

`ifndef ASSERT_OFF
	// a result only ends a command in progress
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a command");

	// after a result the block is free for the next transfer
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result");

	// a value is reported only with success
	a_val_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(found_value != 32'd0) |-> (done && status == ST_OK))
		else $error("value without successful search");

	// one result per accepted command
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("repeated result");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the chained hash table
// Drives insert, search and delete commands with random idle gaps, keeps a
// cycle-accurate-free model of the bucket chains and node pool, and checks
// every result strobe against the expected status and found value.
// ----------------------------------------------------------------------------
module testbench;
	import cht_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] found_value;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = CMD_INSERT;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic        bucket_count_we = 1'b0;
	logic [7:0]  bucket_count = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] found_value;

	// Shadow copy of the table: bucket chains, node pool and free list.
	logic [PTR_BITS-1:0] shadow_heads [BUCKETS];
	logic [31:0]         shadow_keys [NODES];
	logic [31:0]         shadow_values [NODES];
	logic [PTR_BITS-1:0] shadow_links [NODES];
	logic [PTR_BITS-1:0] shadow_free_head;
	logic [PTR_BITS-1:0] shadow_unused;
	logic [7:0]          shadow_bcount;

	table_result_t pending_results [$];
	int            fail_count = 0;
	int            cycle_count = 0;
	bit            no_idle = 1'b0;
	logic [31:0]   key_pool [24];
	logic [31:0]   fill_keys [$];

	chained_hash_table u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.key             (key),
		.value           (value),
		.bucket_count_we (bucket_count_we),
		.bucket_count    (bucket_count),
		.done            (done),
		.status          (status),
		.found_value     (found_value)
	);

	always #1 clk = ~clk;

	// Hard stop: the slowest run is far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [6:0] hash_bucket(logic [31:0] k);
		int n;
		n = shadow_bcount;
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		return 7'(k % n);
	endfunction

	// Apply one command to the shadow table and return its result.
	function automatic table_result_t apply_command(logic [1:0] c, logic [31:0] k,
			logic [31:0] v);
		table_result_t r;
		logic [6:0] b;
		logic [PTR_BITS-1:0] node, cur, prev;
		int steps;
		r.status = ST_NOTFOUND;
		r.found_value = '0;
		b = hash_bucket(k);
		if (c == CMD_INSERT) begin
			node = NIL;
			if (shadow_free_head != NIL) begin
				node = shadow_free_head;
				shadow_free_head = shadow_links[node];
			end else if (shadow_unused < NODES) begin
				node = shadow_unused;
				shadow_unused = shadow_unused + 1'b1;
			end
			if (node == NIL) begin
				r.status = ST_FULL;
			end else begin
				shadow_keys[node] = k;
				shadow_values[node] = v;
				shadow_links[node] = shadow_heads[b];
				shadow_heads[b] = node;
				r.status = ST_OK;
			end
		end else if (c == CMD_SEARCH || c == CMD_DELETE) begin
			cur = shadow_heads[b];
			prev = NIL;
			steps = 0;
			while (cur != NIL && steps < NODES) begin
				if (shadow_keys[cur] == k) begin
					r.status = ST_OK;
					if (c == CMD_SEARCH) begin
						r.found_value = shadow_values[cur];
					end else begin
						// unlink and push onto the free list
						if (prev == NIL) shadow_heads[b] = shadow_links[cur];
						else shadow_links[prev] = shadow_links[cur];
						shadow_links[cur] = shadow_free_head;
						shadow_free_head = cur;
					end
					break;
				end
				prev = cur;
				cur = shadow_links[cur];
				steps++;
			end
		end
		return r;
	endfunction

	// Check each result strobe; done and the result ports are stable at the
	// falling edge.
	always @(negedge clk) begin
		table_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: status %0d value %h",
					status, found_value);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (found_value !== want.found_value) begin
					$error("found_value: expected %h, actual %h",
						want.found_value, found_value);
					fail_count++;
				end
			end
		end
	end

	// Offer one command and hold it until the transfer; predict on transfer.
	task automatic send_command(logic [1:0] c, logic [31:0] k, logic [31:0] v);
		bit taken;
		start <= 1'b1;
		cmd   <= c;
		key   <= k;
		value <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(apply_command(c, k, v));
		if (!no_idle && $urandom_range(99) < 37) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Drop start and wait until every pending result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the bucket count while the table is idle.
	task automatic write_bucket_count(logic [7:0] n);
		drain_results();
		bucket_count_we <= 1'b1;
		bucket_count    <= n;
		@(posedge clk);
		bucket_count_we <= 1'b0;
		shadow_bcount = n;
	endtask

	task automatic test_directed();
		// reset count is 10: keys 0, 10, 20 share bucket 0
		send_command(CMD_SEARCH, 32'd0, 32'hdead_beef);
		send_command(CMD_DELETE, 32'd0, '0);
		send_command(CMD_INSERT, 32'd0, 32'd0);
		send_command(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff);
		send_command(CMD_SEARCH, 32'hffff_ffff, '0);
		send_command(CMD_INSERT, 32'd10, 32'h1111_1111);
		send_command(CMD_INSERT, 32'd20, 32'h2222_2222);
		send_command(CMD_INSERT, 32'd10, 32'h3333_3333);
		send_command(CMD_SEARCH, 32'd10, '0);
		send_command(CMD_DELETE, 32'd10, '0);
		send_command(CMD_SEARCH, 32'd10, '0);
		send_command(CMD_SEARCH, 32'd30, '0);
		send_command(CMD_DELETE, 32'd10, '0);
		send_command(CMD_DELETE, 32'd10, '0);
		send_command(2'd3, 32'd0, 32'h5a5a_5a5a);
		send_command(CMD_SEARCH, 32'd0, '0);
		send_command(CMD_SEARCH, 32'd20, '0);
		send_command(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		send_command(CMD_SEARCH, 32'h8000_0000, '0);
		drain_results();
	endtask

	// Extreme counts, including 0 and values past the bucket array.
	task automatic test_bucket_extremes();
		logic [7:0] counts [5] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd200};
		foreach (counts[i]) begin
			write_bucket_count(counts[i]);
			send_command(CMD_SEARCH, 32'd0, '0);
			send_command(CMD_INSERT, 32'd127 + i, 32'hc0de_0000 + i);
			send_command(CMD_SEARCH, 32'd127 + i, '0);
			send_command(CMD_SEARCH, 32'hffff_ffff, '0);
		end
	endtask

	task automatic test_random();
		logic [31:0] k;
		int pick;
		foreach (key_pool[i])
			key_pool[i] = (i < 4) ? {i[1:0], 30'd0} : $urandom;
		key_pool[4] = 32'hffff_ffff;
		key_pool[5] = 32'd0;
		for (int phase = 0; phase < 4; phase++) begin
			write_bucket_count(phase == 0 ? 8'd1 : 8'($urandom_range(0, 255)));
			no_idle = (phase == 2);
			for (int n = 0; n < 25; n++) begin
				k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(23)] : $urandom;
				pick = $urandom_range(99);
				if (pick < 40) send_command(CMD_INSERT, k, $urandom);
				else if (pick < 70) send_command(CMD_SEARCH, k, $urandom);
				else if (pick < 95) send_command(CMD_DELETE, k, $urandom);
				else send_command(2'd3, k, $urandom);
			end
		end
		no_idle = 1'b0;
		// hold off until the table has answered everything
		drain_results();
	endtask

	// Exhaust the pool, then free a few nodes and reuse them.
	task automatic test_pool_full();
		logic [31:0] k;
		write_bucket_count(8'd128);
		while (shadow_free_head != NIL || shadow_unused < NODES) begin
			k = $urandom;
			fill_keys.push_back(k);
			send_command(CMD_INSERT, k, $urandom);
		end
		repeat (3) send_command(CMD_INSERT, $urandom, $urandom);
		for (int i = 0; i < 4; i++) begin
			send_command(CMD_DELETE, fill_keys[i], '0);
			send_command(CMD_SEARCH, fill_keys[i], '0);
		end
		repeat (6) send_command(CMD_INSERT, $urandom, $urandom);
		send_command(CMD_SEARCH, fill_keys[10], '0);
	endtask

	initial begin
		foreach (shadow_heads[i]) shadow_heads[i] = NIL;
		foreach (shadow_keys[i]) begin
			shadow_keys[i] = '0;
			shadow_values[i] = '0;
			shadow_links[i] = '0;
		end
		shadow_free_head = NIL;
		shadow_unused = '0;
		shadow_bcount = BCNT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_bucket_extremes();
		test_random();
		test_pool_full();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
